// ===== hw/rtl/rcsi_pkg.sv =====
`timescale 1ns / 1ps

package rcsi_pkg;

    localparam int COORD_BITS = 16;
    localparam int NUM_PIECES = 8;
    localparam int CFG_IDX_BITS = 3;
    localparam int PIECE_IDX_BITS = $clog2(NUM_PIECES);

    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_LEFT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_TOP    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_OP_MODE     = 3'd4;

    localparam logic MODE_SUBTRACT  = 1'b0;
    localparam logic MODE_INTERSECT = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord left;
        t_coord top;
        t_coord right;
        t_coord bottom;
    } t_rect;

    typedef struct packed {
        t_rect [NUM_PIECES-1:0] cand;
        logic  [NUM_PIECES-1:0] mask;
        logic                   chg;
    } t_geom;

endpackage

// ===== hw/rtl/rcsi_rect_if.sv =====
`timescale 1ns / 1ps

interface rcsi_rect_if import rcsi_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord rect_left;
    t_coord rect_top;
    t_coord rect_right;
    t_coord rect_bottom;
    logic   list_start;

    modport source (
        output valid, rect_left, rect_top, rect_right, rect_bottom, list_start,
        input  ready
    );
    modport sink (
        input  valid, rect_left, rect_top, rect_right, rect_bottom, list_start,
        output ready
    );
endinterface

// ===== hw/rtl/rcsi_piece_if.sv =====
`timescale 1ns / 1ps

interface rcsi_piece_if import rcsi_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord piece_left;
    t_coord piece_top;
    t_coord piece_right;
    t_coord piece_bottom;
    logic   piece_valid;
    logic   piece_last;
    logic   rect_changed;
    logic   list_changed;

    modport source (
        output valid, piece_left, piece_top, piece_right, piece_bottom,
               piece_valid, piece_last, rect_changed, list_changed,
        input  ready
    );
    modport sink (
        input  valid, piece_left, piece_top, piece_right, piece_bottom,
               piece_valid, piece_last, rect_changed, list_changed,
        output ready
    );
endinterface

// ===== hw/rtl/rcsi_geom.sv =====
`timescale 1ns / 1ps

module rcsi_geom import rcsi_pkg::*; (
    input  t_rect i_rect,
    input  t_rect i_clip,
    input  logic  i_mode,
    output t_geom o_geom
);

    t_coord il, it, ir, ib;
    logic   ov_empty;
    t_rect  r;
    t_rect  ov;
    t_rect  sub [NUM_PIECES];
    logic   [NUM_PIECES-1:0] sub_mask;

    function automatic t_rect mk(t_coord l, t_coord t, t_coord rr, t_coord b);
        t_rect x;
        x.left   = l;
        x.top    = t;
        x.right  = rr;
        x.bottom = b;
        return x;
    endfunction

    always_comb begin
        r  = i_rect;
        il = (r.left > i_clip.left) ? r.left : i_clip.left;
        it = (r.top > i_clip.top) ? r.top : i_clip.top;
        ir = (r.right < i_clip.right) ? r.right : i_clip.right;
        ib = (r.bottom < i_clip.bottom) ? r.bottom : i_clip.bottom;
        ov_empty = (ir <= il) || (ib <= it);
        ov = mk(il, it, ir, ib);

        sub[0] = mk(r.left, r.top, il, it);
        sub[1] = mk(il, r.top, ir, it);
        sub[2] = mk(ir, r.top, r.right, it);
        sub[3] = mk(r.left, it, il, ib);
        sub[4] = mk(ir, it, r.right, ib);
        sub[5] = mk(r.left, ib, il, r.bottom);
        sub[6] = mk(il, ib, ir, r.bottom);
        sub[7] = mk(ir, ib, r.right, r.bottom);

        for (int i = 0; i < NUM_PIECES; i++) begin
            sub_mask[i] = (sub[i].left < sub[i].right) && (sub[i].top < sub[i].bottom);
            o_geom.cand[i] = sub[i];
        end

        if (i_mode == MODE_SUBTRACT) begin
            if (!ov_empty) begin
                o_geom.mask = sub_mask;
                o_geom.chg  = 1'b1;
            end else begin
                o_geom.cand[0] = r;
                o_geom.mask    = NUM_PIECES'(1);
                o_geom.chg     = 1'b0;
            end
        end else begin
            o_geom.cand[0] = ov;
            if (ov_empty) begin
                o_geom.mask = '0;
                o_geom.chg  = 1'b1;
            end else begin
                o_geom.mask = NUM_PIECES'(1);
                o_geom.chg  = (ov != r);
            end
        end
    end

endmodule

// ===== hw/rtl/rect_clip_subtract_intersect.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// i_rect    in   valid/ready    rect_left/top/right/bottom, list_start
// o_piece   out  valid/ready    piece_left/top/right/bottom, piece_valid,
//                               piece_last, rect_changed, list_changed
// cfg       in   i_cfg_we       i_cfg_idx, i_cfg_data (no read-back)
//
// One result per cycle unless o_piece stalls: a rectangle gives one to
// eight results: one per piece, or a lone empty result if there is none.
// A rectangle giving one result is taken every cycle unless o_piece stalls.
// Reset is synchronous: clip registers, mode and list flag clear to zero.
// i_rect.ready drops while pieces of the held rectangle remain or the
// output register is stalled.

module rect_clip_subtract_intersect import rcsi_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [COORD_BITS-1:0]    i_cfg_data,
    rcsi_rect_if.sink                i_rect,
    rcsi_piece_if.source             o_piece
);

    t_rect r_clip;
    logic  r_mode;
    logic  r_flag;

    logic                  r_v;
    t_rect                 r_rect;
    logic                  r_ls;
    logic [NUM_PIECES-1:0] r_done;

    logic   r_ov;
    t_rect  r_out;
    logic   r_pv, r_last, r_rchg, r_lchg;

    t_geom                     geom;
    logic [NUM_PIECES-1:0]     rem;
    logic [PIECE_IDX_BITS-1:0] sel;
    logic                      last;
    logic                      lc;
    logic                      out_ok;
    logic                      emit;
    logic                      take;

    rcsi_geom u_geom (
        .i_rect (r_rect),
        .i_clip (r_clip),
        .i_mode (r_mode),
        .o_geom (geom)
    );

    always_comb begin
        rem = geom.mask & ~r_done;
        sel = '0;
        for (int i = NUM_PIECES - 1; i >= 0; i--) begin
            if (rem[i]) begin
                sel = PIECE_IDX_BITS'(i);
            end
        end
        last   = ((rem & (rem - NUM_PIECES'(1))) == '0);
        lc     = (r_ls ? 1'b0 : r_flag) | geom.chg;
        out_ok = !r_ov || o_piece.ready;
        emit   = r_v && out_ok;
        take   = i_rect.valid && i_rect.ready;
    end

    assign i_rect.ready = !r_v || (out_ok && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= '0;
            r_mode <= MODE_SUBTRACT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CLIP_LEFT:   r_clip.left   <= t_coord'(i_cfg_data);
                REG_CLIP_TOP:    r_clip.top    <= t_coord'(i_cfg_data);
                REG_CLIP_RIGHT:  r_clip.right  <= t_coord'(i_cfg_data);
                REG_CLIP_BOTTOM: r_clip.bottom <= t_coord'(i_cfg_data);
                REG_OP_MODE:     r_mode        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= 1'b0;
            r_done <= '0;
            r_flag <= 1'b0;
        end else begin
            if (emit && last) begin
                r_flag <= lc;
            end
            if (take) begin
                r_v    <= 1'b1;
                r_done <= '0;
            end else if (emit && last) begin
                r_v <= 1'b0;
            end else if (emit) begin
                r_done[sel] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rect.left   <= i_rect.rect_left;
            r_rect.top    <= i_rect.rect_top;
            r_rect.right  <= i_rect.rect_right;
            r_rect.bottom <= i_rect.rect_bottom;
            r_ls          <= i_rect.list_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (o_piece.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (geom.mask == '0) begin
                r_out <= '0;
                r_pv  <= 1'b0;
            end else begin
                r_out <= geom.cand[sel];
                r_pv  <= 1'b1;
            end
            r_last <= last;
            r_rchg <= geom.chg;
            r_lchg <= lc;
        end
    end

    assign o_piece.valid        = r_ov;
    assign o_piece.piece_left   = r_out.left;
    assign o_piece.piece_top    = r_out.top;
    assign o_piece.piece_right  = r_out.right;
    assign o_piece.piece_bottom = r_out.bottom;
    assign o_piece.piece_valid  = r_pv;
    assign o_piece.piece_last   = r_last;
    assign o_piece.rect_changed = r_rchg;
    assign o_piece.list_changed = r_lchg;

    a_hold_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !last) |=> r_v)
        else $error("rectangle released with pieces pending");

    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v |-> ((r_done & ~geom.mask) == '0))
        else $error("emitted piece outside candidate mask");

    a_list_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_rchg) |-> r_lchg)
        else $error("list flag misses rectangle change");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_pv) |-> (r_last && r_rchg))
        else $error("empty result must be last and changed");

endmodule
